[src/tdfr_pkg.sv]
// Shared types, constants and helper functions of the tagged decimal field receiver.
// Used by tdfr_parse, tdfr_scale and tagged_decimal_field_receiver_core.
`default_nettype none

package tdfr_pkg;

  // Default configuration
  localparam int FIELD_LEN_DEF = 6;
  localparam int CHANNELS_DEF  = 10;

  // Fixed widths of the payload
  localparam int BYTE_W     = 8;
  localparam int CHAN_W     = 4;
  localparam int VALUE_W    = 41;
  localparam int OUT_DATA_W = ((CHAN_W + VALUE_W + 7) / 8) * 8;

  // Fraction resolution: the value is counted in units of 1e-5
  localparam int FRAC_UNITS = 5;
  localparam int FRAC_W     = 3;
  localparam int EXP_W      = 3;
  localparam int SCALE_W    = 20;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2e;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;

  // One finished field, handed from the parser to the scaler
  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic              negative;
    logic [EXP_W-1:0]  scale_exp;
  } field_t;

  // Power of ten, evaluated at elaboration only
  function automatic longint pow10(input int n);
    longint p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  // Scale factor 10^exp for the runtime exponent range 0..6
  function automatic logic [SCALE_W-1:0] scale_factor(input logic [EXP_W-1:0] e);
    logic [SCALE_W-1:0] f;
    unique case (e)
      3'd0:    f = 20'd1;
      3'd1:    f = 20'd10;
      3'd2:    f = 20'd100;
      3'd3:    f = 20'd1000;
      3'd4:    f = 20'd10000;
      3'd5:    f = 20'd100000;
      3'd6:    f = 20'd1000000;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

[src/tagged_decimal_field_receiver_core.sv]
// Top level of the tagged decimal field receiver: input register, parser, scaler.
// Depends on tdfr_pkg, tdfr_parse and tdfr_scale.
//
// Takes one received byte per item on the in_ stream, one item per clock while in_tready
// is high. While waiting, a header byte from 1 to CHANNELS opens a field for channel
// header-1; every other byte is dropped. The next FIELD_LEN bytes are read as an ASCII
// decimal number (leading blanks, optional sign, digits, optional point and up to five
// fraction digits; any other character ends the number, an empty number is zero). After
// the last field byte one result item gives the channel and the value in units of 1e-5,
// two's complement, multiplied by ten for every channel but channel 0. A byte passes
// the input register, the parser (one character per cycle unless its field register is
// held) and the scaler (one multiply) with its result register, which drives out_tvalid;
// one byte per cycle is sustained whenever the out_ side takes results as they come.
`default_nettype none

module tagged_decimal_field_receiver_core #(
  parameter int FIELD_LEN = tdfr_pkg::FIELD_LEN_DEF,
  parameter int CHANNELS  = tdfr_pkg::CHANNELS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // in_tdata: [7:0] rx_byte
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [7:0]                         in_tdata,
  // out_tdata: [3:0] channel, [44:4] value, [47:45] zero
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [tdfr_pkg::OUT_DATA_W-1:0]         out_tdata
);

  localparam int MANT_W = $clog2(tdfr_pkg::pow10(FIELD_LEN));
  localparam int PAD_W  = tdfr_pkg::OUT_DATA_W - tdfr_pkg::CHAN_W - tdfr_pkg::VALUE_W;

  logic                          s1_valid_r;
  logic [tdfr_pkg::BYTE_W-1:0]   s1_byte_r;
  logic                          s1_ready;
  logic                          parse_ready;

  logic                          fld_valid;
  logic                          fld_ready;
  tdfr_pkg::field_t              fld;
  logic [MANT_W-1:0]             fld_mant;

  logic [tdfr_pkg::CHAN_W-1:0]   out_channel;
  logic signed [tdfr_pkg::VALUE_W-1:0] out_value;

  // Input register
  assign s1_ready  = !s1_valid_r || parse_ready;
  assign in_tready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && s1_ready) begin
      s1_byte_r <= in_tdata;
    end
  end

  tdfr_parse #(
    .FIELD_LEN (FIELD_LEN),
    .CHANNELS  (CHANNELS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r),
    .in_byte   (s1_byte_r),
    .in_ready  (parse_ready),
    .fld_valid (fld_valid),
    .fld_ready (fld_ready),
    .fld       (fld),
    .fld_mant  (fld_mant)
  );

  tdfr_scale #(
    .FIELD_LEN (FIELD_LEN)
  ) u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .fld_valid   (fld_valid),
    .fld_ready   (fld_ready),
    .fld         (fld),
    .fld_mant    (fld_mant),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_channel (out_channel),
    .out_value   (out_value)
  );

  // Pack the result item
  assign out_tdata = {{PAD_W{1'b0}}, out_value, out_channel};

endmodule

`default_nettype wire

[src/tdfr_parse.sv]
// Header detection and per-character decimal parser with its field register.
// Depends on tdfr_pkg.
`default_nettype none

module tdfr_parse #(
  parameter int FIELD_LEN = tdfr_pkg::FIELD_LEN_DEF,
  parameter int CHANNELS  = tdfr_pkg::CHANNELS_DEF
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst_n,
  input  wire logic                                           in_valid,
  input  wire logic [tdfr_pkg::BYTE_W-1:0]                    in_byte,
  output logic                                                in_ready,
  output logic                                                fld_valid,
  input  wire logic                                           fld_ready,
  output tdfr_pkg::field_t                                    fld,
  output logic [$clog2(tdfr_pkg::pow10(FIELD_LEN))-1:0]       fld_mant
);

  localparam int MANT_W = $clog2(tdfr_pkg::pow10(FIELD_LEN));
  localparam int CNT_W  = $clog2(FIELD_LEN + 1);
  localparam int FRAC_W = tdfr_pkg::FRAC_W;
  localparam int CHAN_W = tdfr_pkg::CHAN_W;

  // Parse state
  logic [CHAN_W-1:0] mode_r,       mode_nxt;
  logic [CNT_W-1:0]  byte_count_r, byte_count_nxt;
  logic              negative_r,   negative_nxt;
  logic              point_r,      point_nxt;
  logic [FRAC_W-1:0] frac_r,       frac_nxt;
  logic [MANT_W-1:0] mantissa_r,   mantissa_nxt;
  logic              started_r,    started_nxt;
  logic              stopped_r,    stopped_nxt;

  // Field register
  logic              fld_valid_r;
  tdfr_pkg::field_t  fld_r,        fld_nxt;
  logic [MANT_W-1:0] fld_mant_r;

  // Character reading result
  logic              neg_rd, pnt_rd, start_rd, stop_rd;
  logic [FRAC_W-1:0] frac_rd;
  logic [MANT_W-1:0] mant_rd;

  logic              in_fire;
  logic              idle;
  logic              is_header;
  logic              is_digit;
  logic              is_blank;
  logic              done;
  logic [MANT_W+3:0] mant_ext;
  logic [MANT_W+3:0] mant_x10;
  logic [3:0]        digit;
  logic [CHAN_W-1:0] chan;

  assign in_ready  = !fld_valid_r || fld_ready;
  assign in_fire   = in_valid && in_ready;
  assign fld_valid = fld_valid_r;
  assign fld       = fld_r;
  assign fld_mant  = fld_mant_r;

  // Classify the incoming byte
  assign idle      = (mode_r == '0) || (mode_r > CHAN_W'(CHANNELS));
  assign is_header = (in_byte >= 8'd1) && (in_byte <= tdfr_pkg::BYTE_W'(CHANNELS));
  assign is_digit  = (in_byte >= tdfr_pkg::CH_ZERO) && (in_byte <= tdfr_pkg::CH_NINE);
  assign is_blank  = (in_byte == tdfr_pkg::CH_SPACE) ||
                     ((in_byte >= tdfr_pkg::CH_TAB) && (in_byte <= tdfr_pkg::CH_CR));
  assign digit     = 4'(in_byte - tdfr_pkg::CH_ZERO);
  assign done      = (byte_count_r == CNT_W'(FIELD_LEN - 1));
  assign chan      = mode_r - 1'b1;

  // Append one digit: mantissa * 10 + digit
  assign mant_ext  = {4'b0000, mantissa_r};
  assign mant_x10  = (mant_ext << 3) + (mant_ext << 1) + {{MANT_W{1'b0}}, digit};

  // Read one field character
  always_comb begin
    neg_rd   = negative_r;
    pnt_rd   = point_r;
    frac_rd  = frac_r;
    mant_rd  = mantissa_r;
    start_rd = started_r;
    stop_rd  = stopped_r;
    if (!stopped_r) begin
      if (is_digit) begin
        start_rd = 1'b1;
        if (!point_r) begin
          mant_rd = mant_x10[MANT_W-1:0];
        end else if (frac_r < FRAC_W'(tdfr_pkg::FRAC_UNITS)) begin
          frac_rd = frac_r + 1'b1;
          mant_rd = mant_x10[MANT_W-1:0];
        end
      end else if ((in_byte == tdfr_pkg::CH_DOT) && !point_r) begin
        start_rd = 1'b1;
        pnt_rd   = 1'b1;
      end else if (((in_byte == tdfr_pkg::CH_PLUS) || (in_byte == tdfr_pkg::CH_MINUS)) &&
                   !started_r) begin
        start_rd = 1'b1;
        neg_rd   = (in_byte == tdfr_pkg::CH_MINUS);
      end else if (is_blank && !started_r) begin
        // skip leading whitespace
      end else begin
        stop_rd = 1'b1;
      end
    end
  end

  // Next parse state and finished field
  always_comb begin
    mode_nxt       = mode_r;
    byte_count_nxt = byte_count_r + 1'b1;
    negative_nxt   = neg_rd;
    point_nxt      = pnt_rd;
    frac_nxt       = frac_rd;
    mantissa_nxt   = mant_rd;
    started_nxt    = start_rd;
    stopped_nxt    = stop_rd;
    fld_nxt.chan      = chan;
    fld_nxt.negative  = neg_rd;
    fld_nxt.scale_exp = tdfr_pkg::EXP_W'(tdfr_pkg::FRAC_UNITS) - frac_rd +
                        tdfr_pkg::EXP_W'(chan != '0);
    if (idle || done) begin
      mode_nxt       = idle ? (is_header ? in_byte[CHAN_W-1:0] : '0) : '0;
      byte_count_nxt = '0;
      negative_nxt   = 1'b0;
      point_nxt      = 1'b0;
      frac_nxt       = '0;
      mantissa_nxt   = '0;
      started_nxt    = 1'b0;
      stopped_nxt    = 1'b0;
    end
  end

  // Advance parse state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= '0;
      byte_count_r <= '0;
      negative_r   <= 1'b0;
      point_r      <= 1'b0;
      frac_r       <= '0;
      mantissa_r   <= '0;
      started_r    <= 1'b0;
      stopped_r    <= 1'b0;
    end else if (in_fire) begin
      mode_r       <= mode_nxt;
      byte_count_r <= byte_count_nxt;
      negative_r   <= negative_nxt;
      point_r      <= point_nxt;
      frac_r       <= frac_nxt;
      mantissa_r   <= mantissa_nxt;
      started_r    <= started_nxt;
      stopped_r    <= stopped_nxt;
    end
  end

  // Hold the finished field until the scaler takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fld_valid_r <= 1'b0;
    end else if (in_fire) begin
      fld_valid_r <= !idle && done;
    end else if (fld_ready) begin
      fld_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !idle && done) begin
      fld_r      <= fld_nxt;
      fld_mant_r <= mant_rd;
    end
  end

  // Checks
  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r <= CHAN_W'(CHANNELS))
    else $error("mode beyond channel count");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == '0) |-> ((byte_count_r == '0) && (mantissa_r == '0) && !started_r))
    else $error("field state not cleared while waiting for header");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r < CNT_W'(FIELD_LEN))
    else $error("byte count reached field length");

  a_field_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fld_valid_r) |-> $past(in_fire && (mode_r != '0)))
    else $error("field produced without a field byte");

endmodule

`default_nettype wire

[src/tdfr_scale.sv]
// Power-of-ten scaling, sign and result register of the receiver.
// Depends on tdfr_pkg.
`default_nettype none

module tdfr_scale #(
  parameter int FIELD_LEN = tdfr_pkg::FIELD_LEN_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      fld_valid,
  output logic                                           fld_ready,
  input  wire tdfr_pkg::field_t                          fld,
  input  wire logic [$clog2(tdfr_pkg::pow10(FIELD_LEN))-1:0] fld_mant,
  output logic                                           out_valid,
  input  wire logic                                      out_ready,
  output logic [tdfr_pkg::CHAN_W-1:0]                    out_channel,
  output logic signed [tdfr_pkg::VALUE_W-1:0]            out_value
);

  localparam int MANT_W  = $clog2(tdfr_pkg::pow10(FIELD_LEN));
  localparam int SCALE_W = tdfr_pkg::SCALE_W;
  localparam int VALUE_W = tdfr_pkg::VALUE_W;
  localparam int PROD_W  = MANT_W + SCALE_W;
  localparam int WIDE_W  = (PROD_W > VALUE_W) ? PROD_W : VALUE_W;

  logic                      out_valid_r;
  logic [tdfr_pkg::CHAN_W-1:0] channel_r;
  logic signed [VALUE_W-1:0] value_r;

  logic [SCALE_W-1:0] scale;
  logic [PROD_W-1:0]  prod;
  logic [WIDE_W-1:0]  prod_wide;
  logic [VALUE_W-1:0] mag;
  logic [VALUE_W-1:0] value_nxt;
  logic               fld_fire;

  assign fld_ready   = !out_valid_r || out_ready;
  assign fld_fire    = fld_valid && fld_ready;
  assign out_valid   = out_valid_r;
  assign out_channel = channel_r;
  assign out_value   = value_r;

  // Scale to units of 1e-5, wrap to the value width, apply sign
  assign scale     = tdfr_pkg::scale_factor(fld.scale_exp);
  assign prod      = {{SCALE_W{1'b0}}, fld_mant} * {{MANT_W{1'b0}}, scale};
  assign prod_wide = WIDE_W'(prod);
  assign mag       = prod_wide[VALUE_W-1:0];
  assign value_nxt = fld.negative ? (~mag + 1'b1) : mag;

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fld_ready) begin
      out_valid_r <= fld_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fld_fire) begin
      channel_r <= fld.chan;
      value_r   <= value_nxt;
    end
  end

endmodule

`default_nettype wire
